/* src/nttpb_pkg.sv */
// Shared types and constants for the numeric text to packed BCD converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nttpb_pkg;

  // Nibble codes for the non-digit elements of a number
  localparam logic [3:0] NIB_MINUS = 4'd10;
  localparam logic [3:0] NIB_POINT = 4'd11;
  localparam logic [3:0] NIB_EXP   = 4'd12;
  localparam logic [3:0] NIB_SLASH = 4'd13;
  localparam logic [3:0] NIB_END   = 4'd15;

  // ASCII codes that the parser recognizes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UPPER_E = 8'd69;
  localparam logic [7:0] CH_LOWER_E = 8'd101;

  // Parse phases
  typedef enum logic [2:0] {
    PH_WS,
    PH_INT,
    PH_FRAC,
    PH_EXPSIGN,
    PH_EXPDIG,
    PH_SLASH,
    PH_DEN,
    PH_DONE
  } phase_t;

  // Character class of one input transaction
  typedef struct packed {
    logic       is_digit;
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       is_point;
    logic       is_exp;
    logic       is_slash;
    logic       is_nul;
    logic [3:0] digit;
  } char_class_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       byte_valid;
    logic       number_done;
    logic       no_digit_error;
  } result_t;

endpackage

/* src/nttpb_classify.sv */
// Character classifier: decodes one ASCII code into the classes the parser uses.
// Depends on nttpb_pkg.
`timescale 1ns / 1ps

module nttpb_classify (
  input  logic [7:0]                char_code,
  output nttpb_pkg::char_class_t    char_class
);
  import nttpb_pkg::*;

  // Compare against each recognized code; digit value is the low nibble of c - '0'
  always_comb begin
    char_class.is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    char_class.is_space = (char_code == CH_SPACE) ||
                          ((char_code >= CH_TAB) && (char_code <= CH_CR));
    char_class.is_plus  = (char_code == CH_PLUS);
    char_class.is_minus = (char_code == CH_MINUS);
    char_class.is_point = (char_code == CH_POINT);
    char_class.is_exp   = (char_code == CH_UPPER_E) || (char_code == CH_LOWER_E);
    char_class.is_slash = (char_code == CH_SLASH);
    char_class.is_nul   = (char_code == CH_NUL);
    char_class.digit    = char_code[3:0] - CH_ZERO[3:0];
  end

endmodule

/* src/nttpb_step.sv */
// Parser state machine: phase, held nibble and digit flag, plus the byte packer.
// Depends on nttpb_pkg; takes classified characters from nttpb_classify.
`timescale 1ns / 1ps

module nttpb_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  nttpb_pkg::char_class_t char_class,
  output logic                   res_en,
  output nttpb_pkg::result_t     res
);
  import nttpb_pkg::*;

  phase_t     phase_r,   phase_nxt;
  logic [3:0] held_r,    held_nxt;
  logic       is_held_r, is_held_nxt;
  logic       seen_r,    seen_nxt;

  // Action decoded for the current character
  phase_t     act_phase;
  logic       act_add;
  logic [3:0] act_nib;
  logic       act_pair;
  logic       act_fin;
  logic       act_clear;
  logic       act_seen;

  // Decode the character against the phase
  always_comb begin
    act_phase = phase_r;
    act_add   = 1'b0;
    act_nib   = char_class.digit;
    act_pair  = 1'b0;
    act_fin   = 1'b0;
    act_clear = 1'b0;
    act_seen  = 1'b0;
    unique case (phase_r)
      PH_WS, PH_INT: begin
        if (phase_r == PH_WS && char_class.is_space) begin
          act_phase = PH_WS;
        end else if (phase_r == PH_WS && char_class.is_plus) begin
          act_phase = PH_INT;
        end else if (phase_r == PH_WS && char_class.is_minus) begin
          act_phase = PH_INT;
          act_add   = 1'b1;
          act_nib   = NIB_MINUS;
        end else begin
          // integer part; whitespace phase falls into it
          act_phase = PH_INT;
          if (char_class.is_digit) begin
            act_seen = 1'b1;
            act_add  = 1'b1;
          end else if (char_class.is_point) begin
            act_phase = PH_FRAC;
            act_add   = 1'b1;
            act_nib   = NIB_POINT;
          end else if (char_class.is_exp) begin
            act_phase = PH_EXPSIGN;
            act_add   = 1'b1;
            act_nib   = NIB_EXP;
          end else if (char_class.is_slash && seen_r) begin
            act_phase = PH_SLASH;
          end else begin
            act_fin = 1'b1;
          end
        end
      end
      PH_FRAC: begin
        if (char_class.is_digit) begin
          act_seen = 1'b1;
          act_add  = 1'b1;
        end else if (char_class.is_exp) begin
          act_phase = PH_EXPSIGN;
          act_add   = 1'b1;
          act_nib   = NIB_EXP;
        end else begin
          act_fin = 1'b1;
        end
      end
      PH_EXPSIGN: begin
        if (char_class.is_plus) begin
          act_phase = PH_EXPDIG;
        end else if (char_class.is_minus) begin
          act_phase = PH_EXPDIG;
          act_add   = 1'b1;
          act_nib   = NIB_MINUS;
        end else if (char_class.is_digit) begin
          act_phase = PH_EXPDIG;
          act_add   = 1'b1;
        end else begin
          act_fin = 1'b1;
        end
      end
      PH_EXPDIG, PH_DEN: begin
        if (char_class.is_digit) begin
          act_add = 1'b1;
        end else begin
          act_fin = 1'b1;
        end
      end
      PH_SLASH: begin
        if (char_class.is_digit) begin
          act_phase = PH_DEN;
          act_pair  = 1'b1;
        end else begin
          act_fin = 1'b1;
        end
      end
      PH_DONE: begin
        act_clear = char_class.is_nul;
      end
      default: begin
        act_clear = char_class.is_nul;
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt   = act_phase;
    held_nxt    = held_r;
    is_held_nxt = is_held_r;
    seen_nxt    = seen_r | act_seen;
    if (act_add) begin
      held_nxt    = is_held_r ? 4'd0 : act_nib;
      is_held_nxt = ~is_held_r;
    end else if (act_pair) begin
      // slash plus digit: a held nibble closes with the slash and the digit is held
      held_nxt = is_held_r ? char_class.digit : held_r;
    end
    if (act_fin) begin
      phase_nxt   = PH_DONE;
      held_nxt    = 4'd0;
      is_held_nxt = 1'b0;
    end
    if (act_clear || (act_fin && char_class.is_nul)) begin
      phase_nxt   = PH_WS;
      held_nxt    = 4'd0;
      is_held_nxt = 1'b0;
      seen_nxt    = 1'b0;
    end
  end

  // Result for the current character
  always_comb begin
    res_en             = 1'b0;
    res.packed_byte    = 8'd0;
    res.byte_valid     = 1'b0;
    res.number_done    = 1'b0;
    res.no_digit_error = 1'b0;
    if (act_add && is_held_r) begin
      res_en          = 1'b1;
      res.packed_byte = {held_r, act_nib};
      res.byte_valid  = 1'b1;
    end else if (act_pair) begin
      res_en          = 1'b1;
      res.packed_byte = is_held_r ? {held_r, NIB_SLASH} : {NIB_SLASH, char_class.digit};
      res.byte_valid  = 1'b1;
    end else if (act_fin) begin
      res_en             = 1'b1;
      res.packed_byte    = is_held_r ? {held_r, NIB_END} : 8'd0;
      res.byte_valid     = is_held_r;
      res.number_done    = 1'b1;
      res.no_digit_error = ~seen_r;
    end
  end

  // Advance the state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WS;
      held_r    <= 4'd0;
      is_held_r <= 1'b0;
      seen_r    <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      is_held_r <= is_held_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

/* src/nttpb_out_reg.sv */
// Result register: holds one result transaction until the consumer takes it.
// Depends on nttpb_pkg.
`timescale 1ns / 1ps

module nttpb_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  nttpb_pkg::result_t res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output nttpb_pkg::result_t out_res
);
  import nttpb_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Slot is free when empty or being drained this cycle
  assign free = ~valid_r | out_ready;

  // Hold until taken, refill on load
  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* src/numeric_text_to_packed_bcd.sv */
// Top level of the numeric text to packed BCD converter.
// Depends on nttpb_pkg, nttpb_classify, nttpb_step and nttpb_out_reg.
`timescale 1ns / 1ps

// Reads number text one ASCII character per transaction (code 0 ends a string)
// and emits packed BCD bytes, two nibbles each, first nibble in bits 7..4:
// digits 0-9, minus 10, point 11, exponent 12, slash 13, end mark 15. Each
// character is decoded and the parser state updated in the cycle it is
// accepted, so one character is taken per clock; the single result register
// sets the rate when the consumer stalls, since a new character is accepted
// only while that register is empty or being drained. A result appears on
// the output in the cycle after the character causing it. The result that
// closes a number carries number_done, and no_digit_error when the mantissa
// had no digit; characters after it are dropped up to the terminator.
module numeric_text_to_packed_bcd (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_packed_byte,
  output logic       out_byte_valid,
  output logic       out_number_done,
  output logic       out_no_digit_error
);
  import nttpb_pkg::*;

  char_class_t char_class;
  result_t     step_res;
  result_t     out_res;
  logic        step_en;
  logic        res_en;
  logic        slot_free;

  // Accept a transaction whenever the result slot can take its output
  assign in_ready = slot_free;
  assign step_en  = in_valid & in_ready;

  nttpb_classify u_classify (
    .char_code  (in_char_code),
    .char_class (char_class)
  );

  nttpb_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .char_class (char_class),
    .res_en     (res_en),
    .res        (step_res)
  );

  nttpb_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en & res_en),
    .res       (step_res),
    .free      (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_packed_byte    = out_res.packed_byte;
  assign out_byte_valid     = out_res.byte_valid;
  assign out_number_done    = out_res.number_done;
  assign out_no_digit_error = out_res.no_digit_error;

endmodule

/* tb/sv/packed_bcd_checker.sv */
// Checker for the numeric text to packed BCD converter: watches both channels,
// predicts the packed BCD results and compares them. Depends on nttpb_pkg.
`timescale 1ns / 1ps

module packed_bcd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_packed_byte,
  input  logic       out_byte_valid,
  input  logic       out_number_done,
  input  logic       out_no_digit_error,
  output int         fail_count,
  output int         pending,
  output int         chars_seen,
  output int         bytes_seen,
  output int         numbers_closed,
  output int         empty_mantissas
);
  import nttpb_pkg::*;

  // Parser state of the prediction
  phase_t      stage;
  logic [3:0]  half_nib;
  logic        half_full;
  logic        mant_digit;

  // Results still to come, oldest first
  result_t     expected_bytes[$];
  result_t     want;

  int errors;
  int n_chars;
  int n_bytes;
  int n_done;
  int n_empty;

  task automatic clear_parse();
    stage      = PH_WS;
    half_nib   = 4'd0;
    half_full  = 1'b0;
    mant_digit = 1'b0;
  endtask

  // Hold a first nibble, or emit a full byte with the second one
  task automatic push_nibble(input logic [3:0] nib);
    if (half_full) begin
      expected_bytes.push_back({half_nib, nib, 1'b1, 1'b0, 1'b0});
      half_nib  = 4'd0;
      half_full = 1'b0;
    end else begin
      half_nib  = nib;
      half_full = 1'b1;
    end
  endtask

  // End the number: close a half byte with the end mark, flag a bare mantissa
  task automatic close_number(input logic [7:0] c);
    expected_bytes.push_back({half_full ? {half_nib, NIB_END} : 8'h00,
                              half_full, 1'b1, !mant_digit});
    if (c == CH_NUL) begin
      clear_parse();
    end else begin
      stage     = PH_DONE;
      half_nib  = 4'd0;
      half_full = 1'b0;
    end
  endtask

  // Advance the parse by one character
  task automatic predict_packed_bytes(input logic [7:0] c);
    logic       digit;
    logic       space;
    logic       expo;
    logic [3:0] d;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    expo  = (c == CH_LOWER_E) || (c == CH_UPPER_E);
    // the digit codes start on a multiple of 16, so the low nibble is the value
    d     = c[3:0];

    // Skip whitespace and take a sign; anything else starts the integer part
    if (stage == PH_WS) begin
      if (space) return;
      stage = PH_INT;
      if (c == CH_PLUS) return;
      if (c == CH_MINUS) begin
        push_nibble(NIB_MINUS);
        return;
      end
    end

    case (stage)
      PH_INT: begin
        if (digit) begin
          mant_digit = 1'b1;
          push_nibble(d);
        end else if (c == CH_POINT) begin
          stage = PH_FRAC;
          push_nibble(NIB_POINT);
        end else if (expo) begin
          stage = PH_EXPSIGN;
          push_nibble(NIB_EXP);
        end else if (c == CH_SLASH && mant_digit) begin
          stage = PH_SLASH;
        end else begin
          close_number(c);
        end
      end
      PH_FRAC: begin
        if (digit) begin
          mant_digit = 1'b1;
          push_nibble(d);
        end else if (expo) begin
          stage = PH_EXPSIGN;
          push_nibble(NIB_EXP);
        end else begin
          close_number(c);
        end
      end
      PH_EXPSIGN: begin
        if (c == CH_PLUS) begin
          stage = PH_EXPDIG;
        end else if (c == CH_MINUS) begin
          stage = PH_EXPDIG;
          push_nibble(NIB_MINUS);
        end else if (digit) begin
          stage = PH_EXPDIG;
          push_nibble(d);
        end else begin
          close_number(c);
        end
      end
      PH_EXPDIG, PH_DEN: begin
        if (digit) push_nibble(d);
        else close_number(c);
      end
      PH_SLASH: begin
        // a digit confirms the slash: a held nibble closes with the slash, else slash and digit form a byte
        if (digit) begin
          stage = PH_DEN;
          if (half_full) begin
            expected_bytes.push_back({half_nib, NIB_SLASH, 1'b1, 1'b0, 1'b0});
            half_nib = d;
          end else begin
            expected_bytes.push_back({NIB_SLASH, d, 1'b1, 1'b0, 1'b0});
          end
        end else begin
          close_number(c);
        end
      end
      default: begin
        // drop trailing text up to the terminator
        if (c == CH_NUL) clear_parse();
      end
    endcase
  endtask

  // Compare accepted results, then predict from the accepted character
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      expected_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (out_byte_valid) n_bytes++;
        if (out_number_done) n_done++;
        if (out_number_done && out_no_digit_error) n_empty++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result byte=%02h valid=%b done=%b err=%b, expected none",
                   $time, out_packed_byte, out_byte_valid, out_number_done,
                   out_no_digit_error);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_packed_byte !== want.packed_byte) begin
            $display("%0t: packed_byte expected %02h, got %02h",
                     $time, want.packed_byte, out_packed_byte);
            errors++;
          end
          if (out_byte_valid !== want.byte_valid) begin
            $display("%0t: byte_valid expected %b, got %b",
                     $time, want.byte_valid, out_byte_valid);
            errors++;
          end
          if (out_number_done !== want.number_done) begin
            $display("%0t: number_done expected %b, got %b",
                     $time, want.number_done, out_number_done);
            errors++;
          end
          if (out_no_digit_error !== want.no_digit_error) begin
            $display("%0t: no_digit_error expected %b, got %b",
                     $time, want.no_digit_error, out_no_digit_error);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        n_chars++;
        predict_packed_bytes(in_char_code);
      end
    end
    fail_count      <= errors;
    pending         <= expected_bytes.size();
    chars_seen      <= n_chars;
    bytes_seen      <= n_bytes;
    numbers_closed  <= n_done;
    empty_mantissas <= n_empty;
  end

endmodule

/* tb/sv/numeric_text_to_packed_bcd_tb.sv */
// Testbench top for the numeric text to packed BCD converter: drives number
// text with random gaps and stalls and gives the verdict. Depends on nttpb_pkg,
// numeric_text_to_packed_bcd and packed_bcd_checker.
`timescale 1ns / 1ps

module numeric_text_to_packed_bcd_tb;
  import nttpb_pkg::*;

  localparam int ITEM_TARGET = 1600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_char_code = 8'd0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_packed_byte;
  logic       out_byte_valid;
  logic       out_number_done;
  logic       out_no_digit_error;

  int fail_count;
  int pending;
  int chars_seen;
  int bytes_seen;
  int numbers_closed;
  int empty_mantissas;
  int cycle_count = 0;

  // Characters of the string being sent
  logic [7:0] text[$];

  always #5 clk = ~clk;

  numeric_text_to_packed_bcd i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_packed_byte    (out_packed_byte),
    .out_byte_valid     (out_byte_valid),
    .out_number_done    (out_number_done),
    .out_no_digit_error (out_no_digit_error)
  );

  packed_bcd_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_packed_byte    (out_packed_byte),
    .out_byte_valid     (out_byte_valid),
    .out_number_done    (out_number_done),
    .out_no_digit_error (out_no_digit_error),
    .fail_count         (fail_count),
    .pending            (pending),
    .chars_seen         (chars_seen),
    .bytes_seen         (bytes_seen),
    .numbers_closed     (numbers_closed),
    .empty_mantissas    (empty_mantissas)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("numeric_text_to_packed_bcd: mismatch");
      $finish;
    end
  end

  // Receiver: ready runs broken by short stalls, a few long ones, and one
  // long hold-off that backs the block up into its input
  initial begin
    int run;
    int pick;
    int elapsed;
    bit held_off;
    elapsed  = 0;
    held_off = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      run = $urandom_range(1, 40);
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      elapsed += run;
      if (!held_off && elapsed >= 400) begin
        held_off = 1'b1;
        run = 300;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 2) run = 0;
        else if (pick < 9) run = $urandom_range(1, 3);
        else run = $urandom_range(10, 50);
      end
      if (run > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (run - 1) @(negedge clk);
        elapsed += run;
      end
    end
  end

  // Send the current string; bursts go without gaps
  task automatic send_text(input bit burst);
    int gap;
    int pick;
    foreach (text[i]) begin
      pick = $urandom_range(0, 19);
      if (burst || pick < 12) gap = 0;
      else if (pick < 18) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      in_valid     <= 1'b1;
      in_char_code <= text[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
  endtask

  // Build one string: mostly well-formed numbers with random content,
  // some with trailing junk, some pure noise; counted excludes ignored junk
  task automatic make_number(output int counted);
    int style;
    int v;
    int n_int;
    text.delete();
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(1, 255)));
      text.push_back(CH_NUL);
      counted = text.size();
      return;
    end
    // leading whitespace
    repeat ($urandom_range(0, 2)) begin
      v = $urandom_range(8, 13);
      text.push_back(v == 8 ? CH_SPACE : 8'(v));
    end
    v = $urandom_range(0, 2);
    if (v == 1) text.push_back(CH_PLUS);
    else if (v == 2) text.push_back(CH_MINUS);
    n_int = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
    repeat (n_int) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    style = $urandom_range(0, 9);
    if (style >= 4 && style <= 6 || style == 9) begin
      text.push_back(CH_POINT);
      if (style != 9)
        repeat ($urandom_range(0, 4)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ((style == 7 || style == 8) && n_int > 0) begin
      // a slash with no digit after it is dropped
      text.push_back(CH_SLASH);
      repeat ($urandom_range(0, 4)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if ($urandom_range(0, 2) == 0) begin
      text.push_back($urandom_range(0, 1) ? CH_UPPER_E : CH_LOWER_E);
      v = $urandom_range(0, 2);
      if (v == 1) text.push_back(CH_PLUS);
      else if (v == 2) text.push_back(CH_MINUS);
      repeat ($urandom_range(0, 3)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    counted = text.size() + 1;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(1, 255)));
    text.push_back(CH_NUL);
  endtask

  // Stimulus and verdict
  initial begin
    int counted;
    int total;
    int strings;
    total   = 0;
    strings = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty string; "\t -1.5E-2"; "+9/05x" with a top code in the trailing
    // text; "\r12/3/"; "7/" cut by the terminator; ".e" closed by code 0x80
    text = {CH_NUL,
            CH_TAB, CH_SPACE, CH_MINUS, 8'h31, CH_POINT, 8'h35, CH_UPPER_E, CH_MINUS,
            8'h32, CH_NUL,
            CH_PLUS, 8'h39, CH_SLASH, 8'h30, 8'h35, 8'h78, 8'hFF, CH_NUL,
            CH_CR, 8'h31, 8'h32, CH_SLASH, 8'h33, CH_SLASH, CH_NUL,
            8'h37, CH_SLASH, CH_NUL,
            CH_POINT, CH_LOWER_E, 8'h80, CH_NUL};
    send_text(1'b0);
    strings = 6;

    while (total < ITEM_TARGET) begin
      make_number(counted);
      send_text($urandom_range(0, 4) == 0);
      total += counted;
      strings++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain the results still owed, then allow for the output register
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d strings, %0d characters accepted in %0d cycles.",
             strings, chars_seen, cycle_count);
    $display("Saw %0d packed bytes and %0d closed numbers, %0d with no mantissa digit.",
             bytes_seen, numbers_closed, empty_mantissas);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("numeric_text_to_packed_bcd: match");
    end else begin
      $display("numeric_text_to_packed_bcd: mismatch");
    end
    $finish;
  end

endmodule
